// ===== rtl/irc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the interval room counter
// no dependencies; used by irc_cell and interval_room_counter_unit
package irc_pkg;

  localparam int unsigned MAX_EVENTS = 256;
  localparam int unsigned TIME_BITS  = 16;

  // cell index and event count widths
  localparam int unsigned IDX_W   = $clog2(MAX_EVENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_EVENTS + 1);

  // result field width and saturation value
  localparam int unsigned ROOMS_W   = 9;
  localparam logic [31:0] ROOMS_MAX = 32'd511;

  // stream data widths
  localparam int unsigned IN_DATA_W  = ((2 * TIME_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ROOMS_W + 7) / 8) * 8;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic                 load;       // insert new_start / new_end
    logic                 shift_s;    // start chain moves one cell toward the head
    logic                 shift_e;    // end chain moves one cell toward the head
    logic [TIME_BITS-1:0] new_start;
    logic [TIME_BITS-1:0] new_end;
    logic [CNT_W-1:0]     count;      // entries held before this insert
  } cell_ctl_t;

  function automatic logic [ROOMS_W-1:0] sat_rooms(input logic [CNT_W-1:0] r);
    logic [31:0] wide;
    wide = 32'(r);
    if (wide > ROOMS_MAX) begin
      return ROOMS_MAX[ROOMS_W-1:0];
    end
    return ROOMS_W'(wide);
  endfunction

endpackage

// ===== rtl/irc_cell.sv =====
`timescale 1ns / 1ps
// one cell of the sorting chain: holds one start and one end time
// depends on irc_pkg
module irc_cell (
  input  logic                          clk_i,
  input  irc_pkg::cell_ctl_t            ctl_i,
  input  logic [irc_pkg::IDX_W-1:0]     idx_i,
  input  logic [irc_pkg::TIME_BITS-1:0] left_start_i,
  input  logic [irc_pkg::TIME_BITS-1:0] left_end_i,
  input  logic [irc_pkg::TIME_BITS-1:0] right_start_i,
  input  logic [irc_pkg::TIME_BITS-1:0] right_end_i,
  output logic [irc_pkg::TIME_BITS-1:0] start_o,
  output logic [irc_pkg::TIME_BITS-1:0] end_o
);

  logic [irc_pkg::TIME_BITS-1:0] start_q, start_d;
  logic [irc_pkg::TIME_BITS-1:0] end_q, end_d;
  logic [irc_pkg::CNT_W-1:0]     idx_ext;
  logic                          own_occ;
  logic                          left_occ;
  logic                          is_tail;

  assign idx_ext  = irc_pkg::CNT_W'(idx_i);
  assign own_occ  = idx_ext < ctl_i.count;
  assign left_occ = (idx_ext != '0) && (idx_ext <= ctl_i.count);
  assign is_tail  = idx_ext == ctl_i.count;

  // insertion: take the left value if it is larger, else the new value
  // if it lands here, else keep; without a load, a shift takes the right value
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (ctl_i.load) begin
      if (left_occ && (left_start_i > ctl_i.new_start)) begin
        start_d = left_start_i;
      end else if (is_tail || (own_occ && (start_q > ctl_i.new_start))) begin
        start_d = ctl_i.new_start;
      end
      if (left_occ && (left_end_i > ctl_i.new_end)) begin
        end_d = left_end_i;
      end else if (is_tail || (own_occ && (end_q > ctl_i.new_end))) begin
        end_d = ctl_i.new_end;
      end
    end else begin
      if (ctl_i.shift_s) begin
        start_d = right_start_i;
      end
      if (ctl_i.shift_e) begin
        end_d = right_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

// ===== rtl/interval_room_counter_unit.sv =====
`timescale 1ns / 1ps
// top level of the interval room counter: load control, sweep and result register
// depends on irc_pkg and irc_cell
//
// usage:
//   input stream (s_axis_*): one event per transaction, tdata = {end_time, start_time},
//   tlast marks the final event of a set. each accepted event is inserted into two
//   sorted chains of cells (starts and ends) in the same cycle, so loading runs at
//   one event per cycle. events beyond MAX_EVENTS are dropped and flagged.
//   after the last event the block sweeps: both chains move toward cell 0, the start
//   chain on every step and the end chain only when a room is reused, so the sweep takes
//   one step per stored event. input is not ready during the sweep.
//   output stream (m_axis_*): one transaction per set, tdata carries rooms_needed,
//   tuser carries overflow. the result sits in an output register, so loading of the
//   next set goes on while it waits; only the final sweep step holds if the previous
//   result is still not taken. reset clears the event count, overflow flag, sweep
//   control and output valid; cell contents are not cleared and only occupied cells
//   are ever read.
module interval_room_counter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // start_time [15:0], end_time [31:16]
  input  logic [irc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // rooms_needed [8:0], zero fill above
  output logic [irc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // overflow [0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  localparam int unsigned TB = irc_pkg::TIME_BITS;
  localparam int unsigned CW = irc_pkg::CNT_W;
  localparam int unsigned N  = irc_pkg::MAX_EVENTS;

  logic                    state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic [CW-1:0]           len_q, len_d;
  logic                    sweep_ovf_q, sweep_ovf_d;
  logic [CW-1:0]           s_q, s_d;
  logic [CW-1:0]           e_q, e_d;
  logic [CW-1:0]           rooms_q, rooms_d;
  logic                    out_valid_q, out_valid_d;
  logic [irc_pkg::ROOMS_W-1:0] out_rooms_q, out_rooms_d;
  logic                    out_ovf_q, out_ovf_d;

  logic                    in_fire;
  logic                    out_fire;
  logic                    full;
  logic                    last_step;
  logic                    step_en;
  logic                    hit;
  logic [CW-1:0]           rooms_nx;
  logic [TB-1:0]           in_start;
  logic [TB-1:0]           in_end;

  irc_pkg::cell_ctl_t      ctl;
  logic [TB-1:0]           cell_start [N];
  logic [TB-1:0]           cell_end   [N];

  assign in_start = s_axis_tdata[TB-1:0];
  assign in_end   = s_axis_tdata[2*TB-1:TB];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;
  assign full          = (32'(count_q) >= N);

  // sweep step: compare the heads of both chains
  assign last_step = (s_q == (len_q - CW'(1)));
  assign step_en   = (state_q == ST_SWEEP) && !(last_step && out_valid_q && !m_axis_tready);
  assign hit       = (e_q < len_q) && (cell_start[0] < cell_end[0]);
  assign rooms_nx  = rooms_q + CW'(hit);

  // command to the cell chain
  always_comb begin
    ctl.load      = in_fire && !full;
    ctl.shift_s   = step_en;
    ctl.shift_e   = step_en && !hit;
    ctl.new_start = in_start;
    ctl.new_end   = in_end;
    ctl.count     = count_q;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [TB-1:0] left_s, left_e, right_s, right_e;
    if (k == 0) begin : g_head
      assign left_s = '0;
      assign left_e = '0;
    end else begin : g_mid
      assign left_s = cell_start[k-1];
      assign left_e = cell_end[k-1];
    end
    if (k == N - 1) begin : g_tail
      assign right_s = cell_start[k];
      assign right_e = cell_end[k];
    end else begin : g_body
      assign right_s = cell_start[k+1];
      assign right_e = cell_end[k+1];
    end
    irc_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .idx_i        (irc_pkg::IDX_W'(k)),
      .left_start_i (left_s),
      .left_end_i   (left_e),
      .right_start_i(right_s),
      .right_end_i  (right_e),
      .start_o      (cell_start[k]),
      .end_o        (cell_end[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    sweep_ovf_d = sweep_ovf_q;
    s_d         = s_q;
    e_d         = e_q;
    rooms_d     = rooms_q;
    out_valid_d = out_valid_q && !out_fire;
    out_rooms_d = out_rooms_q;
    out_ovf_d   = out_ovf_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
          if (s_axis_tlast) begin
            // hand the set to the sweep and start a fresh set
            len_d       = full ? count_q : count_q + CW'(1);
            sweep_ovf_d = ovf_q || full;
            count_d     = '0;
            ovf_d       = 1'b0;
            s_d         = '0;
            e_d         = '0;
            rooms_d     = '0;
            state_d     = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (step_en) begin
          s_d     = s_q + CW'(1);
          rooms_d = rooms_nx;
          if (!hit) begin
            e_d = e_q + CW'(1);
          end
          if (last_step) begin
            out_valid_d = 1'b1;
            out_rooms_d = irc_pkg::sat_rooms(rooms_nx);
            out_ovf_d   = sweep_ovf_q;
            state_d     = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      sweep_ovf_q <= 1'b0;
      s_q         <= '0;
      e_q         <= '0;
      rooms_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      len_q       <= len_d;
      sweep_ovf_q <= sweep_ovf_d;
      s_q         <= s_d;
      e_q         <= e_d;
      rooms_q     <= rooms_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_rooms_q <= out_rooms_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = irc_pkg::OUT_DATA_W'(out_rooms_q);
  assign m_axis_tuser  = out_ovf_q;

`ifndef NO_ASSERTIONS
  // fill count never runs past the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= N)
    else $error("event count exceeds capacity");

  // every sweep step either opens a room or advances the end pointer
  a_sweep_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (32'(rooms_q) + 32'(e_q) == 32'(s_q)))
    else $error("sweep bookkeeping out of balance");

  // a sweep always covers at least one stored event
  a_sweep_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ((len_q != '0) && (s_q < len_q)))
    else $error("sweep length or position invalid");

  // the last event of a set starts the sweep
  a_last_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (state_q == ST_SWEEP))
    else $error("last event did not start a sweep");

  // a taken result is not repeated while loading
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (state_q == ST_LOAD)) |=> !m_axis_tvalid)
    else $error("result presented twice");
`endif

endmodule
